/* hdl/eqpm_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the equal-power pan mixer.
// Used by eqpm_cfg, eqpm_pipe and the top level; depends on nothing else.
`default_nettype none

package eqpm_pkg;

  localparam int NUM_CH         = 4;
  localparam int SAMPLE_BITS    = 16;
  localparam int PAN_TABLE_BITS = 8;

  localparam int GAIN_W   = 15;
  localparam int PAN_W    = 16;
  localparam int MASTER_W = 15;
  localparam int WEIGHT_W = 15;

  localparam int GAIN_RESET = 16384;
  localparam int PAN_ONE    = 16384;

  // register map
  localparam int REG_COUNT     = 2 * NUM_CH;
  localparam int REG_GAIN_BASE = 0;
  localparam int REG_PAN_BASE  = NUM_CH;
  localparam int REG_IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int APB_ADDR_W    = REG_IDX_W + 2;
  localparam int APB_DATA_W    = 32;

  // pan table
  localparam int TAB_N         = 1 << PAN_TABLE_BITS;
  localparam int IDX_W         = PAN_TABLE_BITS + 1;
  localparam int PAN_HALF_STEP = 1 << (14 - PAN_TABLE_BITS);
  localparam int PAN_SHIFT     = 15 - PAN_TABLE_BITS;

  // datapath widths
  localparam int SG_W        = SAMPLE_BITS + GAIN_W;
  localparam int PROD_W      = SG_W + WEIGHT_W;
  localparam int CH_SUM_BITS = $clog2(NUM_CH);
  localparam int ACC_W       = PROD_W + CH_SUM_BITS;
  localparam int MID_SHIFT   = 14;
  localparam int MID_HALF    = 1 << (MID_SHIFT - 1);
  localparam int MID_W       = ACC_W + 1 - MID_SHIFT;
  localparam int MP_W        = MID_W + MASTER_W + 1;
  localparam int OUT_SHIFT   = 28;
  localparam int OUT_HALF    = 1 << (OUT_SHIFT - 1);
  localparam int RND_W       = MP_W + 1 - OUT_SHIFT;
  localparam int OUT_LIM     = (1 << (SAMPLE_BITS - 1)) - 1;

  // stream widths
  localparam int IN_TDATA_W  = ((NUM_CH * SAMPLE_BITS + MASTER_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int NUM_STAGES = 6;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef logic [WEIGHT_W-1:0] sine_tab_t [TAB_N+1];

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [WEIGHT_W-1:0] wl;
    logic [WEIGHT_W-1:0] wr;
  } chan_cfg_t;

  // sin(k*pi/(2N)) in Q14 from a truncated Q30 Taylor series
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + 64'(TAB_N / 2)) >> PAN_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum + 64'd32768) >> 16;
      if (sum > 64'(PAN_ONE)) begin
        sum = 64'(PAN_ONE);
      end
      tab[k] = sum[WEIGHT_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // saturate pan to +/-1 and round it to a table index
  function automatic logic [IDX_W-1:0] pan_index(input logic signed [PAN_W-1:0] pan);
    logic signed [PAN_W:0] sat;
    logic [PAN_W:0]        pos;
    logic [PAN_W:0]        idx;
    sat = (PAN_W+1)'(pan);
    if (pan > PAN_ONE) begin
      sat = (PAN_W+1)'(PAN_ONE);
    end else if (pan < -PAN_ONE) begin
      sat = -(PAN_W+1)'(PAN_ONE);
    end
    pos = sat + (PAN_W+1)'(PAN_ONE) + (PAN_W+1)'(PAN_HALF_STEP);
    idx = pos >> PAN_SHIFT;
    if (idx > (PAN_W+1)'(TAB_N)) begin
      idx = (PAN_W+1)'(TAB_N);
    end
    return idx[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/four_channel_equal_power_pan_mixer_top.sv */
// Top level of the four-channel equal-power pan mixer: APB registers and the mix pipeline.
// Depends on eqpm_pkg, eqpm_cfg and eqpm_pipe.
//
//   port group  direction  payload
//   s_axis      in         tdata: sample_ch0..3 (16 b each), master_level (15 b), pad
//   m_axis      out        tdata: left_out, right_out (16 b each); tuser: clipped
//   apb         in/out     gain_ch0..3 at 0x00..0x0C, pan_ch0..3 at 0x10..0x1C
//
// One frame enters per cycle unless a stall at m_axis has filled the pipeline; a result
// passes through the six register stages of the mix pipeline (two multiplier ranks,
// the channel sum, Q14 rounding, the master multiply and the saturating output register),
// the first of which loads on the edge that takes its request.
// Reset clears the valid bits and loads gain 1.0 and center pan on every channel.
// Each stage holds while full and blocked, so a stall at m_axis fills bubbles first.
`default_nettype none

module four_channel_equal_power_pan_mixer_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3, master_level, zero pad
  input  wire logic [eqpm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // left_out, right_out
  output      logic [eqpm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // clipped
  output      logic                                  m_axis_tuser,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [eqpm_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [eqpm_pkg::APB_DATA_W-1:0]       pwdata,
  output      logic [eqpm_pkg::APB_DATA_W-1:0]       prdata,
  output      logic                                  pready
);

  eqpm_pkg::chan_cfg_t                     chan_cfg [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::SAMPLE_BITS-1:0] left;
  logic signed [eqpm_pkg::SAMPLE_BITS-1:0] right;

  eqpm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .chan_cfg_o (chan_cfg)
  );

  eqpm_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chan_cfg_i  (chan_cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_o      (left),
    .right_o     (right),
    .clip_o      (m_axis_tuser)
  );

  assign m_axis_tdata = eqpm_pkg::OUT_TDATA_W'({right, left});

endmodule

`default_nettype wire

/* hdl/eqpm_cfg.sv */
// APB register file for channel gains and pans, plus pan-law weight lookup per channel.
// Depends on eqpm_pkg.
`default_nettype none

module eqpm_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [eqpm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [eqpm_pkg::APB_DATA_W-1:0]     pwdata,
  output      logic [eqpm_pkg::APB_DATA_W-1:0]     prdata,
  output      logic                                pready,
  output      eqpm_pkg::chan_cfg_t                 chan_cfg_o [eqpm_pkg::NUM_CH]
);

  logic [eqpm_pkg::GAIN_W-1:0]    gain_q [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::GAIN_W-1:0]    gain_d [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::PAN_W-1:0]     pan_q  [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::PAN_W-1:0]     pan_d  [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  logic [eqpm_pkg::IDX_W-1:0]     tab_idx [eqpm_pkg::NUM_CH];

  assign pready  = 1'b1;
  assign reg_idx = paddr[eqpm_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
      gain_d[c] = gain_q[c];
      pan_d[c]  = pan_q[c];
      if (wr_en && (reg_idx == eqpm_pkg::REG_IDX_W'(eqpm_pkg::REG_GAIN_BASE + c))) begin
        gain_d[c] = pwdata[eqpm_pkg::GAIN_W-1:0];
      end
      if (wr_en && (reg_idx == eqpm_pkg::REG_IDX_W'(eqpm_pkg::REG_PAN_BASE + c))) begin
        pan_d[c] = pwdata[eqpm_pkg::PAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
        gain_q[c] <= eqpm_pkg::GAIN_W'(eqpm_pkg::GAIN_RESET);
        pan_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
        gain_q[c] <= gain_d[c];
        pan_q[c]  <= pan_d[c];
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
      if (reg_idx == eqpm_pkg::REG_IDX_W'(eqpm_pkg::REG_GAIN_BASE + c)) begin
        prdata = eqpm_pkg::APB_DATA_W'(gain_q[c]);
      end
      if (reg_idx == eqpm_pkg::REG_IDX_W'(eqpm_pkg::REG_PAN_BASE + c)) begin
        prdata = eqpm_pkg::APB_DATA_W'(pan_q[c]);
      end
    end
  end

  // right weight is sin at the index, left weight its mirror
  always_comb begin
    for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
      tab_idx[c]         = eqpm_pkg::pan_index($signed(pan_q[c]));
      chan_cfg_o[c].gain = gain_q[c];
      chan_cfg_o[c].wr   = eqpm_pkg::SINE_TAB[tab_idx[c]];
      chan_cfg_o[c].wl   = eqpm_pkg::SINE_TAB[eqpm_pkg::IDX_W'(eqpm_pkg::TAB_N) - tab_idx[c]];
    end
  end

endmodule

`default_nettype wire

/* hdl/eqpm_pipe.sv */
// Six-stage mix datapath: gain, pan weight, channel sum, Q14 rounding, master, saturate.
// Depends on eqpm_pkg; per-channel gains and weights come from eqpm_cfg.
`default_nettype none

module eqpm_pipe (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire eqpm_pkg::chan_cfg_t                 chan_cfg_i [eqpm_pkg::NUM_CH],
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [eqpm_pkg::IN_TDATA_W-1:0]     in_data_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [eqpm_pkg::SAMPLE_BITS-1:0] left_o,
  output      logic signed [eqpm_pkg::SAMPLE_BITS-1:0] right_o,
  output      logic                                clip_o
);

  localparam int NS = eqpm_pkg::NUM_STAGES;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS:0]   rdy;

  // stage 0: sample times gain, weights, master
  logic signed [eqpm_pkg::SAMPLE_BITS-1:0] smp      [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::SG_W:0]          sg_full  [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::SG_W-1:0]        sg_q     [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::WEIGHT_W-1:0]           wl_q     [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::WEIGHT_W-1:0]           wr_q     [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::MASTER_W-1:0]           master0_q;
  // stage 1: weighted products
  logic signed [eqpm_pkg::PROD_W:0]        pl_full  [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::PROD_W:0]        pr_full  [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::PROD_W-1:0]      pl_q     [eqpm_pkg::NUM_CH];
  logic signed [eqpm_pkg::PROD_W-1:0]      pr_q     [eqpm_pkg::NUM_CH];
  logic [eqpm_pkg::MASTER_W-1:0]           master1_q;
  // stage 2: channel sums
  logic signed [eqpm_pkg::ACC_W-1:0]       accl_d, accr_d, accl_q, accr_q;
  logic [eqpm_pkg::MASTER_W-1:0]           master2_q;
  // stage 3: round to Q14
  logic signed [eqpm_pkg::ACC_W:0]         midl_sum, midr_sum;
  logic signed [eqpm_pkg::MID_W-1:0]       midl_q, midr_q;
  logic [eqpm_pkg::MASTER_W-1:0]           master3_q;
  // stage 4: master level
  logic signed [eqpm_pkg::MP_W-1:0]        mpl_d, mpr_d, mpl_q, mpr_q;
  // stage 5: round and saturate
  logic signed [eqpm_pkg::MP_W:0]          rl_sum, rr_sum;
  logic signed [eqpm_pkg::RND_W-1:0]       rl, rr;
  logic signed [eqpm_pkg::SAMPLE_BITS-1:0] left_d, right_d, left_q, right_q;
  logic                                    clip_d, clip_q;

  // a stage takes a request when it is empty or its successor moves on
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_comb begin
    for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
      smp[c]     = $signed(in_data_i[c*eqpm_pkg::SAMPLE_BITS +: eqpm_pkg::SAMPLE_BITS]);
      sg_full[c] = smp[c] * $signed({1'b0, chan_cfg_i[c].gain});
      pl_full[c] = sg_q[c] * $signed({1'b0, wl_q[c]});
      pr_full[c] = sg_q[c] * $signed({1'b0, wr_q[c]});
    end
  end

  always_comb begin
    accl_d = '0;
    accr_d = '0;
    for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
      accl_d = accl_d + eqpm_pkg::ACC_W'(pl_q[c]);
      accr_d = accr_d + eqpm_pkg::ACC_W'(pr_q[c]);
    end
  end

  assign midl_sum = (eqpm_pkg::ACC_W+1)'(accl_q) + (eqpm_pkg::ACC_W+1)'(eqpm_pkg::MID_HALF);
  assign midr_sum = (eqpm_pkg::ACC_W+1)'(accr_q) + (eqpm_pkg::ACC_W+1)'(eqpm_pkg::MID_HALF);

  assign mpl_d = midl_q * $signed({1'b0, master3_q});
  assign mpr_d = midr_q * $signed({1'b0, master3_q});

  assign rl_sum = (eqpm_pkg::MP_W+1)'(mpl_q) + (eqpm_pkg::MP_W+1)'(eqpm_pkg::OUT_HALF);
  assign rr_sum = (eqpm_pkg::MP_W+1)'(mpr_q) + (eqpm_pkg::MP_W+1)'(eqpm_pkg::OUT_HALF);
  assign rl     = eqpm_pkg::RND_W'(rl_sum >>> eqpm_pkg::OUT_SHIFT);
  assign rr     = eqpm_pkg::RND_W'(rr_sum >>> eqpm_pkg::OUT_SHIFT);

  // clamp to symmetric full scale
  always_comb begin
    clip_d  = 1'b0;
    left_d  = eqpm_pkg::SAMPLE_BITS'(rl);
    right_d = eqpm_pkg::SAMPLE_BITS'(rr);
    if (rl > eqpm_pkg::OUT_LIM) begin
      left_d = eqpm_pkg::SAMPLE_BITS'(eqpm_pkg::OUT_LIM);
      clip_d = 1'b1;
    end else if (rl < -eqpm_pkg::OUT_LIM) begin
      left_d = -eqpm_pkg::SAMPLE_BITS'(eqpm_pkg::OUT_LIM);
      clip_d = 1'b1;
    end
    if (rr > eqpm_pkg::OUT_LIM) begin
      right_d = eqpm_pkg::SAMPLE_BITS'(eqpm_pkg::OUT_LIM);
      clip_d  = 1'b1;
    end else if (rr < -eqpm_pkg::OUT_LIM) begin
      right_d = -eqpm_pkg::SAMPLE_BITS'(eqpm_pkg::OUT_LIM);
      clip_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
        sg_q[c] <= sg_full[c][eqpm_pkg::SG_W-1:0];
        wl_q[c] <= chan_cfg_i[c].wl;
        wr_q[c] <= chan_cfg_i[c].wr;
      end
      master0_q <= in_data_i[eqpm_pkg::NUM_CH*eqpm_pkg::SAMPLE_BITS +: eqpm_pkg::MASTER_W];
    end
    if (rdy[1]) begin
      for (int c = 0; c < eqpm_pkg::NUM_CH; c++) begin
        pl_q[c] <= pl_full[c][eqpm_pkg::PROD_W-1:0];
        pr_q[c] <= pr_full[c][eqpm_pkg::PROD_W-1:0];
      end
      master1_q <= master0_q;
    end
    if (rdy[2]) begin
      accl_q    <= accl_d;
      accr_q    <= accr_d;
      master2_q <= master1_q;
    end
    if (rdy[3]) begin
      midl_q    <= eqpm_pkg::MID_W'(midl_sum >>> eqpm_pkg::MID_SHIFT);
      midr_q    <= eqpm_pkg::MID_W'(midr_sum >>> eqpm_pkg::MID_SHIFT);
      master3_q <= master2_q;
    end
    if (rdy[4]) begin
      mpl_q <= mpl_d;
      mpr_q <= mpr_d;
    end
    if (rdy[5]) begin
      left_q  <= left_d;
      right_q <= right_d;
      clip_q  <= clip_d;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;
  assign clip_o  = clip_q;

endmodule

`default_nettype wire

/* sim/four_channel_equal_power_pan_mixer_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for four_channel_equal_power_pan_mixer_top: stream frames in, mixes out.
// Depends on eqpm_pkg and the top level; predicts each mix and checks it in order of arrival.

module four_channel_equal_power_pan_mixer_top_test;
  import eqpm_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_CYCLES    = 12;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 700;
  localparam int REG_STRIDE      = 4;
  localparam int REPORT_MAX      = 10;
  localparam int PHASE_ITEMS     = 150;
  localparam int RANDOM_PHASES   = 10;
  localparam int FULL_LIM        = (1 << (SAMPLE_BITS - 1)) - 1;

  typedef struct packed {
    logic [MASTER_W-1:0]                 master;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0]  smp;
  } frame_t;

  typedef struct packed {
    logic                   clipped;
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] left;
  } mix_t;

  class pan_mix_checker;
    longint sine_q14 [TAB_N+1];
    longint gain [NUM_CH];
    int     pan [NUM_CH];
    mix_t   pending_mixes [$];
    int     errors;
    int     noted;

    function new();
      logic [63:0] x, x2, term, sum;
      for (int k = 0; k <= TAB_N; k++) begin
        x    = (64'(k) * HALF_PI_Q30 + 64'(TAB_N / 2)) >> PAN_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        sum = (sum + 64'd32768) >> 16;
        if (sum > 64'(PAN_ONE)) begin
          sum = 64'(PAN_ONE);
        end
        sine_q14[k] = longint'(sum);
      end
      for (int c = 0; c < NUM_CH; c++) begin
        gain[c] = GAIN_RESET;
        pan[c]  = 0;
      end
      errors = 0;
      noted  = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx >= REG_GAIN_BASE && idx < REG_GAIN_BASE + NUM_CH) begin
        gain[idx - REG_GAIN_BASE] = longint'(value[GAIN_W-1:0]);
      end else if (idx >= REG_PAN_BASE && idx < REG_PAN_BASE + NUM_CH) begin
        pan[idx - REG_PAN_BASE] = int'($signed(value[PAN_W-1:0]));
      end
    endfunction

    // add half an LSB, then floor
    function longint round_off(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint saturate(longint acc, longint master, inout logic clip);
      longint v;
      v = round_off(round_off(acc, MID_SHIFT) * master, OUT_SHIFT);
      if (v > FULL_LIM) begin
        v    = FULL_LIM;
        clip = 1'b1;
      end
      if (v < -FULL_LIM) begin
        v    = -FULL_LIM;
        clip = 1'b1;
      end
      return v;
    endfunction

    function mix_t mix_frame(frame_t f);
      longint acc_l, acc_r, s, p, idx, lv, rv;
      logic   clip;
      mix_t   m;
      acc_l = 0;
      acc_r = 0;
      clip  = 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        s = longint'($signed(f.smp[c]));
        p = pan[c];
        if (p > PAN_ONE) p = PAN_ONE;
        if (p < -PAN_ONE) p = -PAN_ONE;
        idx = (p + PAN_ONE + PAN_HALF_STEP) >>> PAN_SHIFT;
        if (idx > TAB_N) idx = TAB_N;
        acc_l += s * gain[c] * sine_q14[TAB_N - idx];
        acc_r += s * gain[c] * sine_q14[idx];
      end
      lv = saturate(acc_l, longint'(f.master), clip);
      rv = saturate(acc_r, longint'(f.master), clip);
      m.left    = lv[SAMPLE_BITS-1:0];
      m.right   = rv[SAMPLE_BITS-1:0];
      m.clipped = clip;
      return m;
    endfunction

    function void note_frame(frame_t f);
      pending_mixes.push_back(mix_frame(f));
      noted++;
    endfunction

    function void check_mix(logic [SAMPLE_BITS-1:0] left, logic [SAMPLE_BITS-1:0] right,
                            logic clip);
      mix_t e;
      if (pending_mixes.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected mix: L=%0d R=%0d clip=%0b", $signed(left), $signed(right), clip);
        end
      end else begin
        e = pending_mixes.pop_front();
        if (left !== e.left || right !== e.right || clip !== e.clipped) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("mix mismatch: expected L=%0d R=%0d clip=%0b, got L=%0d R=%0d clip=%0b",
                     $signed(e.left), $signed(e.right), e.clipped,
                     $signed(left), $signed(right), clip);
          end
        end
      end
    endfunction

    function int pending();
      return pending_mixes.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  pan_mix_checker mixes = new();
  bit rx_holding = 1'b0;
  bit hold_off_done = 1'b0;
  int burst_left = 0;
  int idle_cycles = 0;

  four_channel_equal_power_pan_mixer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_sender_gap();
    if (rx_holding) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(30, 100);
    end
    return pick_gap();
  endfunction

  function automatic frame_t make_frame(int s0, int s1, int s2, int s3, int master);
    frame_t f;
    f.smp[0] = s0[SAMPLE_BITS-1:0];
    f.smp[1] = s1[SAMPLE_BITS-1:0];
    f.smp[2] = s2[SAMPLE_BITS-1:0];
    f.smp[3] = s3[SAMPLE_BITS-1:0];
    f.master = master[MASTER_W-1:0];
    return f;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      4, 5:    return $urandom_range(0, 511) - 256;
      6:       return FULL_LIM;
      7:       return -FULL_LIM - 1;
      8:       return $urandom_range(20000, 32767);
      9:       return $urandom_range(0, 12768) - 32768;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic frame_t rand_frame();
    int master;
    case ($urandom_range(0, 9))
      8:       master = PAN_ONE;
      9:       master = $urandom_range(0, 32767);
      default: master = $urandom_range(0, PAN_ONE);
    endcase
    return make_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(), master);
  endfunction

  // hold valid across back-to-back requests, drop it only for a gap
  task automatic send_frame(input frame_t f);
    int gap;
    gap = pick_sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(f);
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    mixes.note_frame(f);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_frame(rand_frame());
  endtask

  // pause the sender until every mix is back and the pipeline is empty
  task automatic drain_mixes();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mixes.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    mixes.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits are sometimes junk; the register keeps only its own width
  task automatic load_channel(input int c, input int gain, input int pan);
    logic [31:0] gw, pw;
    gw = 32'(gain[GAIN_W-1:0]);
    pw = 32'(pan);
    if ($urandom_range(0, 3) == 0) begin
      gw = ($urandom() & ~32'h7FFF) | gw;
      pw = ($urandom() & ~32'hFFFF) | {16'h0, pw[15:0]};
    end
    apb_write(REG_GAIN_BASE + c, gw);
    apb_write(REG_PAN_BASE + c, pw);
  endtask

  task automatic load_random_channels();
    int gain, pan;
    for (int c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(0, 5))
        0:       gain = 0;
        1:       gain = 24576;
        2:       gain = GAIN_RESET;
        5:       gain = $urandom_range(0, 32767);
        default: gain = $urandom_range(0, 24576);
      endcase
      case ($urandom_range(0, 6))
        0:       pan = -PAN_ONE;
        1:       pan = PAN_ONE;
        2:       pan = 0;
        3:       pan = $urandom_range(0, 65535) - 32768;
        default: pan = $urandom_range(0, 2 * PAN_ONE) - PAN_ONE;
      endcase
      load_channel(c, gain, pan);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: unity gain, center pan
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(32767, 32767, 32767, 32767, PAN_ONE));
    send_frame(make_frame(-32768, -32768, -32768, -32768, PAN_ONE));
    send_frame(make_frame(32767, 0, 0, 0, PAN_ONE));
    send_frame(make_frame(-32768, 0, 0, 0, PAN_ONE));
    send_frame(make_frame(1, 0, 0, 0, PAN_ONE));
    send_frame(make_frame(-1, 0, 0, 0, PAN_ONE));
    send_frame(make_frame(32767, 32767, 32767, 32767, 0));
    send_frame(make_frame(32767, 32767, 32767, 32767, 32767));
    send_frame(make_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555));
    send_frame(make_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA));
    send_frame(make_frame(32767, -32768, 32767, -32768, PAN_ONE));
    send_frame(make_frame(3, -5, 7, -9, 1));
    send_frame(make_frame(16384, 16384, 16384, 16384, 8192));

    // maximum in-range gain, hard left and right
    drain_mixes();
    for (int c = 0; c < NUM_CH; c++) begin
      load_channel(c, 24576, (c % 2 == 0) ? -PAN_ONE : PAN_ONE);
    end
    send_frame(make_frame(32767, 32767, 32767, 32767, PAN_ONE));
    send_frame(make_frame(-32768, -32768, -32768, -32768, PAN_ONE));
    send_frame(make_frame(32767, 0, 0, 0, PAN_ONE));
    send_frame(make_frame(0, 32767, 0, 0, PAN_ONE));
    send_frame(make_frame(1234, -4321, 999, -7, 0));
    send_frame(make_frame(100, 100, 100, 100, PAN_ONE));
    send_random(PHASE_ITEMS);

    // zero and over-range gains, pans beyond hard left and right
    drain_mixes();
    load_channel(0, 0, 32767);
    load_channel(1, 32767, -32768);
    load_channel(2, 24576, PAN_ONE - 1);
    load_channel(3, 1, -PAN_ONE - 1);
    send_random(PHASE_ITEMS);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_mixes();
      load_random_channels();
      send_random(PHASE_ITEMS);
    end

    drain_mixes();
    if (mixes.errors == 0 && mixes.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random ready with one long hold-off to back the pipeline up
  initial begin
    int run_len, gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_off_done && mixes.noted >= HOLD_OFF_AT) begin
        m_axis_tready <= 1'b0;
        rx_holding = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        rx_holding    = 1'b0;
        hold_off_done = 1'b1;
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
        m_axis_tready <= 1'b1;
        repeat (run_len) @(negedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      mixes.check_mix(m_axis_tdata[SAMPLE_BITS-1:0],
                      m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], m_axis_tuser);
    end
  end

  // end the run if no request moves on any port for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready)
          || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
hdl/eqpm_pkg.sv
hdl/eqpm_cfg.sv
hdl/eqpm_pipe.sv
hdl/four_channel_equal_power_pan_mixer_top.sv
sim/four_channel_equal_power_pan_mixer_top_test.sv
